>>> design/mpl2n_pkg.sv
// Shared types, constants and codes for the mean pooling and L2 normalization block.
package mpl2n_pkg;

	localparam int DIM_MAX_DEF    = 512;
	localparam int MAX_TOKENS_DEF = 512;
	localparam int DIM_W          = 10;
	localparam int VAL_W          = 32;
	localparam int FRAC_SH        = 30;
	localparam int ACC_W          = 74;
	localparam int ROOT_W         = 37;
	localparam int SPLIT_W        = 21;

	localparam logic [DIM_W-1:0] DIM_RESET = 10'd384;

	localparam logic OP_ACC   = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FINAL = 2'd2;
	localparam logic [1:0] ST_ERROR     = 2'd3;

	typedef struct packed {
		logic             op;
		logic [VAL_W-1:0] value;
		logic             eos;
	} item_t;

endpackage

>>> design/mpl2n_front.sv
// Front end: accepts input items and holds them in a two-entry queue for the back end.
module mpl2n_front import mpl2n_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic signed [VAL_W-1:0] element_value,
	input  logic                    end_of_sequence,
	output logic                    q_valid,
	output item_t                   q_item,
	input  logic                    q_pop
);

	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= '{op: opcode, value: element_value, eos: end_of_sequence};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

>>> design/mpl2n_div.sv
// Restoring divider that produces one quotient bit per cycle.
module mpl2n_div import mpl2n_pkg::*; #(
	parameter int DVD_W = 72,
	parameter int DVS_W = ROOT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem2;
	logic             ge;

	assign rem2     = {rem_q, dvd_q[DVD_W-1]};
	assign ge       = (rem2 >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? DVS_W'(rem2 - {1'b0, dvs_q}) : rem2[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/mpl2n_back.sv
// Back end: sum store, finalize sequencer, square root, drain and output register.
module mpl2n_back import mpl2n_pkg::*; #(
	parameter int DIM_MAX    = DIM_MAX_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [DIM_W-1:0]        dim,
	input  logic                    q_valid,
	input  item_t                   q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] normalized_value,
	output logic                    last_component,
	output logic [1:0]              status
);

	localparam int POS_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
	localparam int CNT_W = $clog2(DIM_MAX + 1);
	localparam int TOK_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS + 1) : 1;
	localparam int SUM_W = 33 + $clog2(MAX_TOKENS);
	localparam int DVD_W = SUM_W + FRAC_SH;
	localparam int A_W   = SUM_W - SPLIT_W;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQC_W = $clog2(ROOT_W);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ACC_RD  = 4'd1;
	localparam logic [3:0] S_ACC_WR  = 4'd2;
	localparam logic [3:0] S_FIN_RD  = 4'd3;
	localparam logic [3:0] S_FIN_ST  = 4'd4;
	localparam logic [3:0] S_FIN_DIV = 4'd5;
	localparam logic [3:0] S_FIN_SQ  = 4'd6;
	localparam logic [3:0] S_FIN_ACC = 4'd7;
	localparam logic [3:0] S_SQRT    = 4'd8;
	localparam logic [3:0] S_DR_RD   = 4'd9;
	localparam logic [3:0] S_DR_ST   = 4'd10;
	localparam logic [3:0] S_DR_DIV1 = 4'd11;
	localparam logic [3:0] S_DR_DIV2 = 4'd12;

	localparam logic [DIM_W:0] DMAX = (DIM_W + 1)'(DIM_MAX);

	logic [SUM_W-1:0] mem [DIM_MAX];
	logic [SUM_W-1:0] rdata_q;
	logic             rhit_q;

	logic [3:0]        state_q;
	item_t             item_q;
	logic [POS_W-1:0]  pos_q;
	logic [TOK_W-1:0]  tok_q;
	logic [CNT_W-1:0]  fill_q;
	logic [POS_W-1:0]  drain_q;
	logic [CNT_W-1:0]  idx_q;
	logic              phase_q;
	logic              err_q;
	logic [ROOT_W-1:0] norm_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SQC_W-1:0]  sqc_q;
	logic              sneg_q;
	logic              mneg_q;
	logic [SUM_W-1:0]  mean_q;
	logic [2*A_W-1:0]  pa_q;
	logic [A_W+SPLIT_W-1:0] pb_q;
	logic [2*SPLIT_W-1:0]   pc_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_val_q;
	logic              out_last_q;
	logic [1:0]        out_st_q;

	logic [DIM_W:0]    d_full;
	logic [CNT_W-1:0]  d;
	logic [POS_W-1:0]  raddr;
	logic              we;
	logic [SUM_W-1:0]  base;
	logic [SUM_W-1:0]  mag;
	logic [SUM_W-1:0]  wdata;
	logic [TOK_W-1:0]  n;
	logic              add_en;
	logic [CNT_W-1:0]  pos_inc;
	logic              wrap;
	logic [CNT_W-1:0]  drain_inc;
	logic              drain_last;
	logic [CNT_W-1:0]  idx_inc;
	logic [63:0]       sq;
	logic [ACC_W-1:0]  acc_new;
	logic [REM_W-1:0]  rem2;
	logic [REM_W-1:0]  trial;
	logic              sq_ge;
	logic [ROOT_W-1:0] root_new;
	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [ROOT_W-1:0] div_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;
	logic [SUM_W-1:0]  mean_now;
	logic [VAL_W-1:0]  res_val;
	logic              do_clear;

	always_comb begin
		if (dim == '0) d_full = (DIM_W + 1)'(1);
		else if ({1'b0, dim} > DMAX) d_full = DMAX;
		else d_full = {1'b0, dim};
	end
	assign d = CNT_W'(d_full);

	assign n          = (tok_q == '0) ? TOK_W'(1) : tok_q;
	assign add_en     = (tok_q < TOK_W'(MAX_TOKENS));
	assign pos_inc    = CNT_W'(pos_q) + CNT_W'(1);
	assign wrap       = (pos_inc >= d);
	assign drain_inc  = CNT_W'(drain_q) + CNT_W'(1);
	assign drain_last = (drain_inc >= d);
	assign idx_inc    = idx_q + CNT_W'(1);

	assign base  = rhit_q ? rdata_q : '0;
	assign mag   = base[SUM_W-1] ? SUM_W'(-base) : base;
	assign wdata = base + {{(SUM_W - VAL_W){item_q.value[VAL_W-1]}}, item_q.value};
	assign we    = (state_q == S_ACC_WR) && add_en;

	always_comb begin
		case (state_q)
			S_ACC_RD: raddr = pos_q;
			S_DR_RD:  raddr = drain_q;
			default:  raddr = idx_q[POS_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[pos_q] <= wdata;
		rdata_q <= mem[raddr];
		rhit_q  <= (CNT_W'(raddr) < fill_q);
	end

	assign sq = (64'(pa_q) << (2 * SPLIT_W)) + (64'(pb_q) << (SPLIT_W + 1)) + 64'(pc_q);
	assign acc_new = acc_q + ACC_W'(sq);

	assign rem2     = {rem_q[REM_W-3:0], rad_q[ACC_W-1:ACC_W-2]};
	assign trial    = REM_W'({root_q, 2'b01});
	assign sq_ge    = (rem2 >= trial);
	assign root_new = {root_q[ROOT_W-2:0], sq_ge};

	assign mean_now = div_quot[SUM_W-1:0];

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'(mag) + DVD_W'(n >> 1);
		div_dvs   = ROOT_W'(n);
		case (state_q)
			S_FIN_ST, S_DR_ST: div_start = 1'b1;
			S_DR_DIV1: begin
				div_start = div_done;
				div_dvd   = {mean_now, {FRAC_SH{1'b0}}} + DVD_W'(norm_q >> 1);
				div_dvs   = norm_q;
			end
			default: ;
		endcase
	end

	mpl2n_div #(.DVD_W(DVD_W), .DVS_W(ROOT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		if (mneg_q) begin
			if (div_quot > DVD_W'(33'h0_8000_0000)) res_val = 32'h8000_0000;
			else res_val = VAL_W'(~div_quot[VAL_W-1:0] + VAL_W'(1));
		end else begin
			if (div_quot > DVD_W'(32'h7FFF_FFFF)) res_val = 32'h7FFF_FFFF;
			else res_val = div_quot[VAL_W-1:0];
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && (q_item.op == OP_ACC || !out_valid_q);

	always_comb begin
		do_clear = 1'b0;
		if (q_pop && q_item.op == OP_ACC && phase_q) do_clear = 1'b1;
		if (q_pop && q_item.op == OP_DRAIN && phase_q && err_q) do_clear = 1'b1;
		if (state_q == S_DR_DIV2 && div_done && drain_last) do_clear = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (state_q == S_FIN_DIV && div_done) mean_q <= mean_now;
		if (state_q == S_FIN_SQ) begin
			pa_q <= mean_q[SUM_W-1:SPLIT_W] * mean_q[SUM_W-1:SPLIT_W];
			pb_q <= mean_q[SUM_W-1:SPLIT_W] * mean_q[SPLIT_W-1:0];
			pc_q <= mean_q[SPLIT_W-1:0] * mean_q[SPLIT_W-1:0];
		end
		if (state_q == S_DR_ST) sneg_q <= base[SUM_W-1];
		if (state_q == S_DR_DIV1 && div_done) mneg_q <= sneg_q && (mean_now != '0);
		if (state_q == S_FIN_ACC && idx_inc >= d) begin
			rad_q  <= acc_new;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == S_SQRT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= sq_ge ? (rem2 - trial) : rem2;
			root_q <= root_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			tok_q       <= '0;
			fill_q      <= '0;
			drain_q     <= '0;
			idx_q       <= '0;
			phase_q     <= 1'b0;
			err_q       <= 1'b0;
			norm_q      <= '0;
			acc_q       <= '0;
			sqc_q       <= '0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_last_q  <= 1'b0;
			out_st_q    <= ST_OK;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_item.op == OP_ACC) begin
							state_q <= S_ACC_RD;
						end else begin
							out_valid_q <= 1'b1;
							out_val_q   <= '0;
							out_last_q  <= 1'b1;
							if (!phase_q) begin
								out_st_q <= (tok_q == '0 && pos_q == '0) ? ST_EMPTY : ST_NOT_FINAL;
							end else if (err_q) begin
								out_st_q <= ST_ERROR;
							end else begin
								out_valid_q <= 1'b0;
								state_q     <= S_DR_RD;
							end
						end
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (pos_q == '0 && !add_en) err_q <= 1'b1;
					if (add_en && pos_inc > fill_q) fill_q <= pos_inc;
					if (wrap) begin
						pos_q <= '0;
						if (add_en) tok_q <= tok_q + TOK_W'(1);
					end else begin
						pos_q <= pos_inc[POS_W-1:0];
					end
					if (item_q.eos) begin
						if (!wrap) err_q <= 1'b1;
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_FIN_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FIN_RD: state_q <= S_FIN_ST;
				S_FIN_ST: state_q <= S_FIN_DIV;
				S_FIN_DIV: if (div_done) state_q <= S_FIN_SQ;
				S_FIN_SQ: state_q <= S_FIN_ACC;
				S_FIN_ACC: begin
					acc_q <= acc_new;
					if (idx_inc >= d) begin
						sqc_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_FIN_RD;
					end
				end
				S_SQRT: begin
					sqc_q <= sqc_q + SQC_W'(1);
					if (sqc_q == SQC_W'(ROOT_W - 1)) begin
						norm_q  <= (root_new == '0) ? ROOT_W'(1) : root_new;
						phase_q <= 1'b1;
						drain_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_DR_RD: state_q <= S_DR_ST;
				S_DR_ST: state_q <= S_DR_DIV1;
				S_DR_DIV1: if (div_done) state_q <= S_DR_DIV2;
				S_DR_DIV2: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						out_val_q   <= res_val;
						out_last_q  <= drain_last;
						out_st_q    <= ST_OK;
						if (!drain_last) drain_q <= drain_inc[POS_W-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (do_clear) begin
				pos_q   <= '0;
				tok_q   <= '0;
				fill_q  <= '0;
				drain_q <= '0;
				phase_q <= 1'b0;
				err_q   <= 1'b0;
				norm_q  <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign normalized_value = out_val_q;
	assign last_component   = out_last_q;
	assign status           = out_st_q;

endmodule

>>> design/mean_pool_l2_normalize.sv
// Top level: mean pooling of a token sequence with L2 normalization of the mean vector.
// Accumulate: the back end reads and writes back each element's sum; a two-entry queue takes items meanwhile.
// Finalize: for each dimension, read the sum, divide it by the token count, square the mean and
// accumulate it, then take the square root. Drain: each result reads its sum and divides twice.
// Reset clears all control state and the sum store fill count; the store needs no clearing pass.
module mean_pool_l2_normalize import mpl2n_pkg::*; #(
	parameter int DIM_MAX    = DIM_MAX_DEF,
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic signed [VAL_W-1:0] element_value,
	input  logic                    end_of_sequence,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] normalized_value,
	output logic                    last_component,
	output logic [1:0]              status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [DIM_W-1:0]        cfg_data
);

	logic [DIM_W-1:0] dim_q;
	logic             q_valid;
	item_t            q_item;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= cfg_data;
		end
	end

	mpl2n_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.element_value   (element_value),
		.end_of_sequence (end_of_sequence),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	mpl2n_back #(.DIM_MAX(DIM_MAX), .MAX_TOKENS(MAX_TOKENS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.dim              (dim_q),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.normalized_value (normalized_value),
		.last_component   (last_component),
		.status           (status)
	);

endmodule
